[hdl/sed_pkg.sv]
`default_nettype none
package sed_pkg;

	// sprite memory organization
	localparam int unsigned SPRITES_PER_BANK = 1024;

	// field widths
	localparam int CODE_W  = 13;
	localparam int PAL_W   = 7;
	localparam int SX_W    = 10;
	localparam int SY_W    = 9;
	localparam int POSX_W  = 9;
	localparam int POSY_W  = 8;
	localparam int LAYER_W = 3;
	localparam int XOFF_W  = 9;
	localparam int YOFF_W  = 8;
	localparam int ALU_W   = 13;
	localparam int CIDX_W  = 2;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_X_OFFSET       = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_Y_OFFSET       = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_SCREEN_FLIPPED = 2'd2;

	// tile mask and fixed position biases
	localparam logic [ALU_W-1:0] TILE_MASK   = ALU_W'(SPRITES_PER_BANK - 1);
	localparam logic [ALU_W-1:0] Y_BASE      = ALU_W'(240);
	localparam logic [ALU_W-1:0] FLIPX_BASE  = ALU_W'(496);
	localparam logic [ALU_W-1:0] FLIPX_WIDE  = ALU_W'(496 - 16);
	localparam logic [ALU_W-1:0] FLIPY_BASE  = ALU_W'(240);
	localparam logic [ALU_W-1:0] FLIPY_TALL  = ALU_W'(240 - 16);
	localparam logic [SX_W-1:0]  PX_BIAS     = SX_W'(1024 - 67);
	localparam logic [SY_W-1:0]  PY_BIAS     = SY_W'(1);

	typedef struct packed {
		logic [7:0]         y_pos;
		logic [7:0]         attr_b;
		logic [7:0]         x_low;
		logic [7:0]         color_byte;
		logic [7:0]         tile_number;
		logic [7:0]         attr_a;
		logic [LAYER_W-1:0] draw_layer;
	} entry_t;

	typedef struct packed {
		logic [XOFF_W-1:0] x_offset;
		logic [YOFF_W-1:0] y_offset;
		logic              screen_flipped;
	} cfg_t;

	// one piece request from the sequencer to the output stage
	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [PAL_W-1:0]  palette;
		logic              mirror_x;
		logic              mirror_y;
		logic [POSX_W-1:0] pos_x;
		logic [POSY_W-1:0] pos_y;
		logic              row;
		logic              col;
		logic              tall;
		logic              wide;
	} piece_t;

	// first tile of a bank
	function automatic logic [ALU_W-1:0] bank_base(input logic [2:0] bank);
		logic [31:0] prod;
		prod = 32'(bank) * 32'(SPRITES_PER_BANK);
		return prod[ALU_W-1:0];
	endfunction

endpackage
`default_nettype wire

[hdl/sed_alu.sv]
`default_nettype none
module sed_alu import sed_pkg::*; (
	input  wire logic [ALU_W-1:0] a,
	input  wire logic [ALU_W-1:0] b,
	input  wire logic             sub,
	output logic      [ALU_W-1:0] y
);

	// a + b, or a - b in two's complement
	assign y = a + (sub ? ~b : b) + ALU_W'(sub);

endmodule
`default_nettype wire

[hdl/sed_ctrl.sv]
`default_nettype none
module sed_ctrl import sed_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	output logic        in_ready,
	input  wire entry_t in_entry,
	input  wire cfg_t   cfg,
	output logic        piece_valid,
	input  wire logic   piece_ready,
	output piece_t      piece
);

	typedef enum logic [9:0] {
		ST_IDLE = 10'b00_0000_0001,
		ST_CODE = 10'b00_0000_0010,
		ST_HALF = 10'b00_0000_0100,
		ST_SX   = 10'b00_0000_1000,
		ST_SY0  = 10'b00_0001_0000,
		ST_SY1  = 10'b00_0010_0000,
		ST_SY2  = 10'b00_0100_0000,
		ST_FLX  = 10'b00_1000_0000,
		ST_FLY  = 10'b01_0000_0000,
		ST_EMIT = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;

	logic [7:0]        tnum_q;
	logic [2:0]        bank_q;
	logic              right_q, lower_q, wide_q, tall_q, fx_q, fy_q;
	logic [7:0]        color_q;
	logic [7:0]        xl_q;
	logic [7:0]        yp_q;
	logic [CODE_W-1:0] code_q;
	logic [POSX_W-1:0] sx_q;
	logic [POSY_W-1:0] sy_q;
	logic              row_q, col_q;

	logic [ALU_W-1:0] alu_a, alu_b, alu_y;
	logic             alu_sub;
	logic             accept, layer_hit, last_piece;

	sed_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sub (alu_sub),
		.y   (alu_y)
	);

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign layer_hit  = (in_entry.attr_b[7:5] == in_entry.draw_layer);
	assign last_piece = (row_q == tall_q) && (col_q == wide_q);

	// operand selection for the shared adder
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		case (state_q)
			ST_CODE: begin
				alu_a = ALU_W'({tnum_q, 2'b00}) & TILE_MASK;
				alu_b = bank_base(bank_q);
			end
			ST_HALF: begin
				alu_a = code_q;
				alu_b = ALU_W'({lower_q && !tall_q, right_q && !wide_q});
			end
			ST_SX: begin
				alu_a = ALU_W'({color_q[0], xl_q});
				alu_b = {{(ALU_W - XOFF_W){cfg.x_offset[XOFF_W-1]}}, cfg.x_offset};
			end
			ST_SY0: begin
				alu_a   = Y_BASE;
				alu_b   = ALU_W'(yp_q);
				alu_sub = 1'b1;
			end
			ST_SY1: begin
				alu_a   = ALU_W'(sy_q);
				alu_b   = ALU_W'(cfg.y_offset);
				alu_sub = 1'b1;
			end
			ST_SY2: begin
				alu_a   = ALU_W'(sy_q);
				alu_b   = ALU_W'({tall_q, 4'b0000});
				alu_sub = 1'b1;
			end
			ST_FLX: begin
				alu_a   = wide_q ? FLIPX_WIDE : FLIPX_BASE;
				alu_b   = ALU_W'(sx_q);
				alu_sub = 1'b1;
			end
			ST_FLY: begin
				alu_a   = tall_q ? FLIPY_TALL : FLIPY_BASE;
				alu_b   = ALU_W'(sy_q);
				alu_sub = 1'b1;
			end
			default: begin
				alu_a   = '0;
				alu_b   = '0;
				alu_sub = 1'b0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept && layer_hit) state_d = ST_CODE;
			ST_CODE: state_d = ST_HALF;
			ST_HALF: state_d = ST_SX;
			ST_SX:   state_d = ST_SY0;
			ST_SY0:  state_d = ST_SY1;
			ST_SY1:  state_d = ST_SY2;
			ST_SY2:  state_d = ST_FLX;
			ST_FLX:  state_d = ST_FLY;
			ST_FLY:  state_d = ST_EMIT;
			ST_EMIT: if (piece_ready && last_piece) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			tnum_q  <= in_entry.tile_number;
			bank_q  <= in_entry.attr_a[2:0];
			right_q <= in_entry.attr_a[4];
			wide_q  <= in_entry.attr_a[7];
			fx_q    <= in_entry.attr_a[5];
			lower_q <= in_entry.attr_b[4];
			tall_q  <= in_entry.attr_b[2];
			fy_q    <= in_entry.attr_b[0];
			color_q <= in_entry.color_byte;
			xl_q    <= in_entry.x_low;
			yp_q    <= in_entry.y_pos;
			row_q   <= 1'b0;
			col_q   <= 1'b0;
		end
		case (state_q)
			ST_CODE, ST_HALF: code_q <= alu_y[CODE_W-1:0];
			ST_SX:            sx_q   <= alu_y[POSX_W-1:0];
			ST_SY0, ST_SY1, ST_SY2: sy_q <= alu_y[POSY_W-1:0];
			ST_FLX: if (cfg.screen_flipped) sx_q <= alu_y[POSX_W-1:0];
			ST_FLY: if (cfg.screen_flipped) sy_q <= alu_y[POSY_W-1:0];
			ST_EMIT: if (piece_ready) begin
				if (col_q != wide_q) begin
					col_q <= 1'b1;
				end else begin
					col_q <= 1'b0;
					row_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign piece_valid     = (state_q == ST_EMIT);
	assign piece.code      = code_q;
	assign piece.palette   = color_q[7:1];
	assign piece.mirror_x  = fx_q ^ cfg.screen_flipped;
	assign piece.mirror_y  = fy_q ^ cfg.screen_flipped;
	assign piece.pos_x     = sx_q;
	assign piece.pos_y     = sy_q;
	assign piece.row       = row_q;
	assign piece.col       = col_q;
	assign piece.tall      = tall_q;
	assign piece.wide      = wide_q;

endmodule
`default_nettype wire

[hdl/sed_out.sv]
`default_nettype none
module sed_out import sed_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          piece_valid,
	output logic               piece_ready,
	input  wire piece_t        piece,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [CODE_W-1:0]  out_code,
	output logic [PAL_W-1:0]   out_palette,
	output logic               out_mirror_x,
	output logic               out_mirror_y,
	output logic [SX_W-1:0]    out_sx,
	output logic [SY_W-1:0]    out_sy,
	output logic               out_last
);

	logic              valid_q;
	logic              pr, pc, load;
	logic [POSX_W-1:0] px_wrap;
	logic [POSY_W-1:0] py_wrap;

	assign piece_ready = !valid_q || out_ready;
	assign load        = piece_valid && piece_ready;

	// flips reverse the piece order on a doubled axis
	assign pr      = piece.row ^ (piece.tall & piece.mirror_y);
	assign pc      = piece.col ^ (piece.wide & piece.mirror_x);
	assign px_wrap = piece.pos_x + POSX_W'({piece.col, 4'b0000});
	assign py_wrap = piece.pos_y + POSY_W'({piece.row, 4'b0000});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (piece_ready) begin
			valid_q <= piece_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_code     <= piece.code + CODE_W'({pr, pc});
			out_palette  <= piece.palette;
			out_mirror_x <= piece.mirror_x;
			out_mirror_y <= piece.mirror_y;
			out_sx       <= SX_W'(px_wrap) + PX_BIAS;
			out_sy       <= SY_W'(py_wrap) + PY_BIAS;
			out_last     <= (piece.row == piece.tall) && (piece.col == piece.wide);
		end
	end

	assign out_valid = valid_q;

endmodule
`default_nettype wire

[hdl/sprite_entry_decoder.sv]
// sprite entry decoder
// s_axis carries one six-byte sprite list entry plus the layer being drawn.
// entries whose priority differs from draw_layer are taken while idle and
// give nothing. a matching entry gives one, two or four 16x16 pieces on
// m_axis, row by row, left to right, with tlast on the last piece.
// cfg writes x_offset (index 0), y_offset (1) and screen_flipped (2); other
// indexes are ignored. cfg is always ready; the user must write it only
// while idle, which the block itself does not enforce. after an entry is
// accepted the shared 13-bit adder runs eight setup steps (tile code, half
// select, x, three y terms, two flip terms), then one piece leaves per
// cycle while the output register takes it; the next entry is taken after
// the last piece has left. pieces reach m_axis through the output register.
// one output register sits on m_axis; while the receiver stalls the
// sequencer holds its current piece, and s_axis_tready stays low until
// every piece of the entry has gone into the output register.
// reset clears all three registers to zero and empties the output word.
`default_nettype none
module sprite_entry_decoder import sed_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// draw_layer, attr_a, tile_number, color_byte, x_low, attr_b, y_pos
	input  wire logic [55:0]         s_axis_tdata,
	input  wire logic                s_axis_tvalid,
	output logic                     s_axis_tready,
	// tile_code, palette_index, mirror_x, mirror_y, screen_x, screen_y
	output logic [47:0]              m_axis_tdata,
	output logic                     m_axis_tvalid,
	input  wire logic                m_axis_tready,
	output logic                     m_axis_tlast,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [CIDX_W-1:0]   cfg_index,
	input  wire logic [XOFF_W-1:0]   cfg_data
);

	cfg_t   cfg_q;
	entry_t entry;
	piece_t piece;
	logic   piece_valid, piece_ready;

	logic [CODE_W-1:0] tile_code;
	logic [PAL_W-1:0]  palette_index;
	logic              mirror_x, mirror_y;
	logic [SX_W-1:0]   screen_x;
	logic [SY_W-1:0]   screen_y;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_X_OFFSET:       cfg_q.x_offset       <= cfg_data;
				CFG_Y_OFFSET:       cfg_q.y_offset       <= cfg_data[YOFF_W-1:0];
				CFG_SCREEN_FLIPPED: cfg_q.screen_flipped <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input word unpacking, first field lowest
	assign entry.draw_layer  = s_axis_tdata[2:0];
	assign entry.attr_a      = s_axis_tdata[10:3];
	assign entry.tile_number = s_axis_tdata[18:11];
	assign entry.color_byte  = s_axis_tdata[26:19];
	assign entry.x_low       = s_axis_tdata[34:27];
	assign entry.attr_b      = s_axis_tdata[42:35];
	assign entry.y_pos       = s_axis_tdata[50:43];

	// sequencer around the shared adder
	sed_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_entry    (entry),
		.cfg         (cfg_q),
		.piece_valid (piece_valid),
		.piece_ready (piece_ready),
		.piece       (piece)
	);

	// piece formatting and output register
	sed_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.piece_valid  (piece_valid),
		.piece_ready  (piece_ready),
		.piece        (piece),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_code     (tile_code),
		.out_palette  (palette_index),
		.out_mirror_x (mirror_x),
		.out_mirror_y (mirror_y),
		.out_sx       (screen_x),
		.out_sy       (screen_y),
		.out_last     (m_axis_tlast)
	);

	// output word packing, first field lowest, zero filled to 48 bits
	assign m_axis_tdata = {7'b0, screen_y, screen_x, mirror_y, mirror_x,
		palette_index, tile_code};

endmodule
`default_nettype wire

[tb/sed_piece_checker.sv]
// watches the entry, piece and register channels of the sprite entry decoder,
// works out the pieces of every accepted entry and compares them in order
module sed_piece_checker import sed_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// draw_layer, attr_a, tile_number, color_byte, x_low, attr_b, y_pos
	input  wire logic [55:0]       s_axis_tdata,
	input  wire logic              s_axis_tvalid,
	input  wire logic              s_axis_tready,
	// tile_code, palette_index, mirror_x, mirror_y, screen_x, screen_y
	input  wire logic [47:0]       m_axis_tdata,
	input  wire logic              m_axis_tvalid,
	input  wire logic              m_axis_tready,
	input  wire logic              m_axis_tlast,
	input  wire logic              cfg_valid,
	input  wire logic              cfg_ready,
	input  wire logic [CIDX_W-1:0] cfg_index,
	input  wire logic [XOFF_W-1:0] cfg_data,
	output int                     pieces_due,
	output int                     mismatches
);

	typedef struct packed {
		logic [CODE_W-1:0] tile_code;
		logic [PAL_W-1:0]  palette_index;
		logic              mirror_x;
		logic              mirror_y;
		logic [SX_W-1:0]   screen_x;
		logic [SY_W-1:0]   screen_y;
		logic              final_piece;
	} piece_rec_t;

	logic [XOFF_W-1:0] x_off;
	logic [YOFF_W-1:0] y_off;
	logic              flip;
	piece_rec_t        due_pieces[$];
	piece_rec_t        oldest;
	int                bad = 0;

	assign mismatches = bad;

	// queue every piece an entry gives under the current view
	function automatic void decode_pieces(input entry_t e);
		logic [31:0] code, sx, sy, xo, px, py;
		logic        wide, tall, fx, fy, pr, pc;
		piece_rec_t  p;
		if (e.attr_b[7:5] != e.draw_layer)
			return;
		wide = e.attr_a[7];
		tall = e.attr_b[2];
		fx   = e.attr_a[5];
		fy   = e.attr_b[0];
		code = ((32'(e.tile_number) * 4) & (SPRITES_PER_BANK - 1))
			+ 32'(e.attr_a[2:0]) * SPRITES_PER_BANK;
		// half selects only count on an axis that is not doubled
		if (e.attr_a[4] && !wide)
			code += 1;
		if (e.attr_b[4] && !tall)
			code += 2;
		xo = {{23{x_off[8]}}, x_off};
		sx = 32'(e.x_low) + (e.color_byte[0] ? 32'd256 : 32'd0) + xo;
		sy = 32'd240 - 32'(e.y_pos) - 32'(y_off) - (tall ? 32'd16 : 32'd0);
		if (flip) begin
			sx = 32'd496 - (wide ? 32'd16 : 32'd0) - sx;
			sy = 32'd240 - (tall ? 32'd16 : 32'd0) - sy;
			fx = !fx;
			fy = !fy;
		end
		for (int r = 0; r <= int'(tall); r++) begin
			for (int c = 0; c <= int'(wide); c++) begin
				pr = 1'(r) ^ (tall & fy);
				pc = 1'(c) ^ (wide & fx);
				px = ((sx + 32'(16 * c)) & 32'h1ff) - 32'd67;
				py = 32'd1 + ((sy + 32'(16 * r)) & 32'hff);
				p.tile_code     = CODE_W'(code + 32'({pr, pc}));
				p.palette_index = e.color_byte[7:1];
				p.mirror_x      = fx;
				p.mirror_y      = fy;
				p.screen_x      = px[SX_W-1:0];
				p.screen_y      = py[SY_W-1:0];
				p.final_piece   = (r == int'(tall)) && (c == int'(wide));
				due_pieces.push_back(p);
			end
		end
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			bad++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_off <= '0;
			y_off <= '0;
			flip  <= 1'b0;
			due_pieces.delete();
			pieces_due <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_X_OFFSET:       x_off <= cfg_data;
					CFG_Y_OFFSET:       y_off <= cfg_data[YOFF_W-1:0];
					CFG_SCREEN_FLIPPED: flip  <= cfg_data[0];
					default:            ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (due_pieces.size() == 0) begin
					$display("%0t: piece word with nothing expected, tdata %h tlast %b",
						$time, m_axis_tdata, m_axis_tlast);
					bad++;
				end else begin
					oldest = due_pieces.pop_front();
					check_field("tile_code", oldest.tile_code, m_axis_tdata[12:0]);
					check_field("palette_index", oldest.palette_index, m_axis_tdata[19:13]);
					check_field("mirror_x", oldest.mirror_x, m_axis_tdata[20]);
					check_field("mirror_y", oldest.mirror_y, m_axis_tdata[21]);
					check_field("screen_x", $signed(oldest.screen_x),
						$signed(m_axis_tdata[31:22]));
					check_field("screen_y", oldest.screen_y, m_axis_tdata[40:32]);
					check_field("final_piece", oldest.final_piece, m_axis_tlast);
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				decode_pieces(entry_t'(s_axis_tdata[$bits(entry_t)-1:0]));
			pieces_due <= due_pieces.size();
		end
	end

endmodule

[tb/sprite_entry_decoder_test.sv]
// stimulus and verdict for the sprite entry decoder; the checker beside the
// block does all prediction and comparison
module sprite_entry_decoder_test;
	import sed_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	// margin for the longest entry, from accept to its last piece
	localparam int SETTLE      = 20;
	// long receiver hold-off so the block backs up into its input
	localparam int HOLD_OFF    = 150;
	// matching entries per random phase, four phases
	localparam int PER_PHASE   = 92;
	// index past the last register, must be ignored
	localparam logic [CIDX_W-1:0] CFG_UNUSED = 2'd3;

	logic              clk;
	logic              arst_n        = 1'b0;
	logic [55:0]       s_axis_tdata  = '0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [47:0]       m_axis_tdata;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic              m_axis_tlast;
	logic              cfg_valid     = 1'b0;
	logic              cfg_ready;
	logic [CIDX_W-1:0] cfg_index     = '0;
	logic [XOFF_W-1:0] cfg_data      = '0;
	int                pieces_due;
	int                mismatches;
	int                cycles        = 0;
	// bumped by the stimulus at each random phase, answered by the receiver
	int                squeeze_req   = 0;
	// words left in the current sender burst
	int                burst_left    = 0;

	sprite_entry_decoder u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	sed_piece_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.pieces_due    (pieces_due),
		.mismatches    (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("sprite_entry_decoder verification failed");
			$finish;
		end
	end

	// receiver: stretches of always ready, coin flips, a fixed two-of-three
	// pattern and mostly stalled, plus one long hold-off per random phase
	initial begin : receiver
		int mode;
		int span;
		int tick;
		int seen;
		tick = 0;
		seen = 0;
		forever begin
			if (squeeze_req != seen) begin
				seen = squeeze_req;
				m_axis_tready <= 1'b0;
				repeat (HOLD_OFF) @(posedge clk);
			end
			mode = $urandom_range(0, 3);
			span = $urandom_range(8, 60);
			repeat (span) begin
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					2: m_axis_tready <= (tick % 3) != 0;
					default: m_axis_tready <= $urandom_range(0, 3) == 0;
				endcase
				tick++;
				@(posedge clk);
			end
		end
	end

	function automatic entry_t make_entry(input logic [2:0] layer, input logic [7:0] a,
		input logic [7:0] tnum, input logic [7:0] col, input logic [7:0] xl,
		input logic [7:0] b, input logic [7:0] yp);
		entry_t e;
		e.draw_layer  = layer;
		e.attr_a      = a;
		e.tile_number = tnum;
		e.color_byte  = col;
		e.x_low       = xl;
		e.attr_b      = b;
		e.y_pos       = yp;
		return e;
	endfunction

	// well formed means the priority matches the layer, so pieces come out
	function automatic entry_t random_entry(input bit well_formed);
		logic [63:0] raw;
		entry_t      e;
		raw = {$urandom, $urandom};
		e = raw[$bits(entry_t)-1:0];
		if (well_formed)
			e.attr_b[7:5] = e.draw_layer;
		return e;
	endfunction

	// offer one word and hold it until taken; gaps only fall between bursts
	task automatic send_entry(input entry_t e);
		int gap;
		s_axis_tdata  <= 56'(e);
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	// wait until every piece is out, then let a dropped entry finish too
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pieces_due != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [XOFF_W-1:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// full view change, plus a stray write that must change nothing
	task automatic set_view(input logic [8:0] xo, input logic [8:0] yo, input logic [8:0] fl);
		write_reg(CFG_X_OFFSET, xo);
		write_reg(CFG_Y_OFFSET, yo);
		write_reg(CFG_SCREEN_FLIPPED, fl);
		write_reg(CFG_UNUSED, 9'($urandom));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// mostly matching entries with random content, some dropped ones mixed in
	task automatic random_phase();
		int     matched;
		entry_t e;
		matched = 0;
		squeeze_req++;
		while (matched < PER_PHASE) begin
			e = random_entry($urandom_range(0, 9) < 8);
			if (e.attr_b[7:5] == e.draw_layer)
				matched++;
			send_entry(e);
		end
		drain();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_view(9'h000, 9'h000, 9'h000);
		// all zero, then everything set: single piece vs four flipped pieces
		send_entry(make_entry(3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		send_entry(make_entry(3'd7, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
		// largest single piece, x_low at the top of its range
		send_entry(make_entry(3'd7, 8'h00, 8'hff, 8'hfe, 8'hff, 8'he0, 8'hff));
		// wide with mirror x
		send_entry(make_entry(3'd1, 8'ha0, 8'h10, 8'h02, 8'h10, 8'h20, 8'h40));
		// wide and tall, both half selects set and ignored
		send_entry(make_entry(3'd2, 8'h90, 8'h20, 8'h04, 8'h20, 8'h54, 8'h20));
		// both half selects taken, mirror y on a single row
		send_entry(make_entry(3'd3, 8'h10, 8'h30, 8'h06, 8'h30, 8'h71, 8'h50));
		// tall with mirror y, top bank
		send_entry(make_entry(3'd4, 8'h07, 8'hff, 8'h09, 8'h80, 8'h85, 8'h00));
		// ignored attribute bits set
		send_entry(make_entry(3'd5, 8'h48, 8'h11, 8'h0a, 8'h70, 8'haa, 8'h80));
		// priority differs from the layer: dropped
		send_entry(make_entry(3'd3, 8'hff, 8'hff, 8'hff, 8'hff, 8'ha0, 8'h10));
		send_entry(make_entry(3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'he0, 8'h00));
		// x at 511, the top of its range
		send_entry(make_entry(3'd6, 8'h05, 8'h40, 8'h01, 8'hff, 8'hc0, 8'hf0));
		// wide and tall near the bottom edge, y wraps
		send_entry(make_entry(3'd0, 8'h80, 8'h00, 8'h00, 8'h00, 8'h04, 8'hff));
		send_entry(make_entry(3'd2, 8'h20, 8'h7f, 8'h3c, 8'h01, 8'h41, 8'h01));
		send_entry(make_entry(3'd1, 8'h06, 8'h80, 8'h81, 8'h00, 8'h3f, 8'hf0));
		send_entry(make_entry(3'd7, 8'h7f, 8'h01, 8'hfe, 8'h01, 8'hfe, 8'h7f));
		send_entry(make_entry(3'd4, 8'hb7, 8'hcc, 8'h55, 8'haa, 8'h95, 8'h33));
		send_entry(make_entry(3'd6, 8'h31, 8'h55, 8'haa, 8'h55, 8'hd5, 8'hcc));
		drain();

		// offset extremes with the screen flipped, then random views, unflipped and free
		set_view(9'h100, 9'h0ff, 9'h001);
		random_phase();
		set_view(9'h0ff, 9'h100, 9'h003);
		random_phase();
		set_view(9'($urandom), 9'($urandom), 9'($urandom) & 9'h1fe);
		random_phase();
		set_view(9'($urandom), 9'($urandom), 9'($urandom));
		random_phase();

		if (mismatches == 0)
			$display("sprite_entry_decoder verification clean");
		else
			$display("sprite_entry_decoder verification failed");
		$finish;
	end

endmodule

[filelist.f]
hdl/sed_pkg.sv
hdl/sed_alu.sv
hdl/sed_ctrl.sv
hdl/sed_out.sv
hdl/sprite_entry_decoder.sv
tb/sed_piece_checker.sv
tb/sprite_entry_decoder_test.sv
